>>> rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared sizes, codes and types of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int MAX_DIM    = 16;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = $clog2(MAX_DIM) + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + $clog2(MAX_DIM) + 2;
    localparam int ACC_HI_W   = ACC_W - (FRAC_W + DATA_W - 1);
    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_WR_A = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_C = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MAC  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RD_C = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CLOAD,
        ST_ISSUE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             use_item;
        logic             c_rd;
        logic             ab_rd;
        logic             c_wr_mac;
        logic             respond;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] n_rows;
        logic [DIM_W-1:0] n_inner;
        logic [DIM_W-1:0] n_cols;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] elem_addr(logic [IDX_W-1:0] r,
                                                    logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    function automatic logic [DIM_W-1:0] dim_used(logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (DIM_W'(v) > lim) ? lim : DIM_W'(v);
    endfunction

endpackage

>>> rtl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Q16.16 matrix multiply-accumulate, C += A * B, over stored 16 x 16 matrices.
// ----------------------------------------------------------------------------
// A command is transferred on a clock edge where start is high and busy is
// low. func selects a write of one A, B or C element, a read of one C element
// or a multiply-accumulate over the sizes held in the three size registers,
// which the user must write through cfg_wr_en, cfg_index and cfg_data while
// idle; the block itself does not enforce this. Every command yields exactly
// one result, shown for a single cycle with done high; the receiver cannot
// stall it, so it must take each result as it comes. Element writes and
// unknown codes go straight to the response state; a read of C passes a read
// state first. A multiply-accumulate steps over each C entry in turn: it loads
// the old value, runs each inner step through the shared 32 x 32 multiplier
// and accumulator, then drains and writes back in states DRAIN1, DRAIN2 and
// WRITE. busy stays high until the result is shown, so the next command can
// be transferred in the cycle in which done is high. Reset sets all sizes to
// 16 and clears the valid flags of C at once, so C reads as zero with no
// clearing pass; A and B hold no defined contents until written.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mma_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [mma_pkg::FUNC_W-1:0]          func,
    input  logic [mma_pkg::IDX_W-1:0]           row,
    input  logic [mma_pkg::IDX_W-1:0]           col,
    input  logic signed [mma_pkg::DATA_W-1:0]   element_value,
    output logic                                done,
    output logic signed [mma_pkg::DATA_W-1:0]   read_value,
    output logic                                status
);

    mma_pkg::dp_cmd_t    cmd;
    mma_pkg::dp_status_t stat;

    mma_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mma_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .row           (row),
        .col           (col),
        .element_value (element_value),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .read_value    (read_value),
        .status        (status)
    );

endmodule

>>> rtl/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Controller: accepts commands and steps the multiply-accumulate loops.
// ----------------------------------------------------------------------------
module mma_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mma_pkg::FUNC_W-1:0]   func,
    input  mma_pkg::dp_status_t          stat,
    output mma_pkg::dp_cmd_t             cmd,
    output logic                         busy
);

    mma_pkg::state_t                 state_reg, state_next;
    logic [mma_pkg::IDX_W-1:0]       i_reg, i_next;
    logic [mma_pkg::IDX_W-1:0]       j_reg, j_next;
    logic [mma_pkg::IDX_W-1:0]       k_reg, k_next;
    logic                            last_i;
    logic                            last_j;
    logic                            last_k;

    assign last_i = ({1'b0, i_reg} + mma_pkg::DIM_W'(1)) == stat.n_rows;
    assign last_j = ({1'b0, j_reg} + mma_pkg::DIM_W'(1)) == stat.n_cols;
    assign last_k = ({1'b0, k_reg} + mma_pkg::DIM_W'(1)) == stat.n_inner;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mma_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                    if (func == mma_pkg::FUNC_MAC)
                    begin
                        if ((stat.n_rows == '0) || (stat.n_cols == '0))
                        begin
                            state_next = mma_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = mma_pkg::ST_CLOAD;
                        end
                    end
                    else if (func == mma_pkg::FUNC_RD_C)
                    begin
                        state_next = mma_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = mma_pkg::ST_RESP;
                    end
                end
            end
            mma_pkg::ST_READ:
            begin
                state_next = mma_pkg::ST_RESP;
            end
            mma_pkg::ST_CLOAD:
            begin
                k_next = '0;
                if (stat.n_inner == '0)
                begin
                    state_next = mma_pkg::ST_DRAIN1;
                end
                else
                begin
                    state_next = mma_pkg::ST_ISSUE;
                end
            end
            mma_pkg::ST_ISSUE:
            begin
                if (last_k)
                begin
                    state_next = mma_pkg::ST_DRAIN1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            mma_pkg::ST_DRAIN1:
            begin
                state_next = mma_pkg::ST_DRAIN2;
            end
            mma_pkg::ST_DRAIN2:
            begin
                state_next = mma_pkg::ST_WRITE;
            end
            mma_pkg::ST_WRITE:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        state_next = mma_pkg::ST_RESP;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = mma_pkg::ST_CLOAD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = mma_pkg::ST_CLOAD;
                end
            end
            mma_pkg::ST_RESP:
            begin
                state_next = mma_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.i        = i_reg;
        cmd.j        = j_reg;
        cmd.k        = k_reg;
        busy         = 1'b1;
        case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            mma_pkg::ST_READ:
            begin
                cmd.c_rd     = 1'b1;
                cmd.use_item = 1'b1;
            end
            mma_pkg::ST_CLOAD:
            begin
                cmd.c_rd = 1'b1;
            end
            mma_pkg::ST_ISSUE:
            begin
                cmd.ab_rd = 1'b1;
            end
            mma_pkg::ST_WRITE:
            begin
                cmd.c_wr_mac = 1'b1;
            end
            mma_pkg::ST_RESP:
            begin
                cmd.respond = 1'b1;
            end
            default:
            begin
                cmd = cmd;
            end
        endcase
    end

endmodule

>>> rtl/mma_datapath.sv
// ----------------------------------------------------------------------------
// mma_datapath
// Size registers, element stores, multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
module mma_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [mma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mma_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [mma_pkg::FUNC_W-1:0]          func,
    input  logic [mma_pkg::IDX_W-1:0]           row,
    input  logic [mma_pkg::IDX_W-1:0]           col,
    input  logic signed [mma_pkg::DATA_W-1:0]   element_value,
    input  mma_pkg::dp_cmd_t                    cmd,
    output mma_pkg::dp_status_t                 stat,
    output logic                                done,
    output logic signed [mma_pkg::DATA_W-1:0]   read_value,
    output logic                                status
);

    logic [mma_pkg::CFG_DATA_W-1:0]  rows_a_reg;
    logic [mma_pkg::CFG_DATA_W-1:0]  inner_dim_reg;
    logic [mma_pkg::CFG_DATA_W-1:0]  cols_b_reg;

    logic [mma_pkg::FUNC_W-1:0]      func_reg;
    logic [mma_pkg::IDX_W-1:0]       row_reg;
    logic [mma_pkg::IDX_W-1:0]       col_reg;
    logic [mma_pkg::DATA_W-1:0]      value_reg;

    logic [mma_pkg::DEPTH-1:0]       c_valid_reg, c_valid_next;
    logic                            c_vld_d1_reg;
    logic                            cload_d1_reg;
    logic                            ab_d1_reg;
    logic                            prod_vld_reg;
    logic signed [mma_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [mma_pkg::ACC_W-1:0]       acc_reg, acc_next;

    logic                            done_reg;
    logic [mma_pkg::DATA_W-1:0]      read_value_reg, read_value_next;
    logic                            status_reg, status_next;

    logic signed [mma_pkg::DATA_W-1:0] a_rd;
    logic signed [mma_pkg::DATA_W-1:0] b_rd;
    logic [mma_pkg::DATA_W-1:0]      c_rd;
    logic [mma_pkg::DATA_W-1:0]      c_eff;

    logic                            item_ok;
    logic                            a_wr;
    logic                            b_wr;
    logic                            c_wr;
    logic [mma_pkg::ADDR_W-1:0]      item_addr;
    logic [mma_pkg::ADDR_W-1:0]      ij_addr;
    logic [mma_pkg::ADDR_W-1:0]      c_rd_addr;
    logic [mma_pkg::ADDR_W-1:0]      c_wr_addr;
    logic [mma_pkg::DATA_W-1:0]      c_wr_data;
    logic [mma_pkg::ACC_HI_W-1:0]    acc_hi;
    logic [mma_pkg::DATA_W-1:0]      sat_value;

    assign stat.n_rows  = mma_pkg::dim_used(rows_a_reg);
    assign stat.n_inner = mma_pkg::dim_used(inner_dim_reg);
    assign stat.n_cols  = mma_pkg::dim_used(cols_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mma_pkg::CFG_DATA_W'(mma_pkg::MAX_DIM);
            inner_dim_reg <= mma_pkg::CFG_DATA_W'(mma_pkg::MAX_DIM);
            cols_b_reg    <= mma_pkg::CFG_DATA_W'(mma_pkg::MAX_DIM);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mma_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                mma_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                mma_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                rows_a_reg    <= rows_a_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            row_reg   <= row;
            col_reg   <= col;
            value_reg <= element_value;
        end
    end

    always_comb
    begin
        case (func_reg)
            mma_pkg::FUNC_WR_A:
                item_ok = ({1'b0, row_reg} < stat.n_rows) && ({1'b0, col_reg} < stat.n_inner);
            mma_pkg::FUNC_WR_B:
                item_ok = ({1'b0, row_reg} < stat.n_inner) && ({1'b0, col_reg} < stat.n_cols);
            mma_pkg::FUNC_WR_C, mma_pkg::FUNC_RD_C:
                item_ok = ({1'b0, row_reg} < stat.n_rows) && ({1'b0, col_reg} < stat.n_cols);
            mma_pkg::FUNC_MAC:
                item_ok = 1'b1;
            default:
                item_ok = 1'b0;
        endcase
    end

    assign item_addr = mma_pkg::elem_addr(row_reg, col_reg);
    assign ij_addr   = mma_pkg::elem_addr(cmd.i, cmd.j);

    assign a_wr = cmd.respond && item_ok && (func_reg == mma_pkg::FUNC_WR_A);
    assign b_wr = cmd.respond && item_ok && (func_reg == mma_pkg::FUNC_WR_B);
    assign c_wr = (cmd.respond && item_ok && (func_reg == mma_pkg::FUNC_WR_C))
                  || cmd.c_wr_mac;

    assign c_rd_addr = cmd.use_item ? item_addr : ij_addr;
    assign c_wr_addr = cmd.c_wr_mac ? ij_addr : item_addr;
    assign c_wr_data = cmd.c_wr_mac ? sat_value : value_reg;

    mma_ram #(
        .WIDTH (mma_pkg::DATA_W),
        .DEPTH (mma_pkg::DEPTH)
    ) u_a_ram (
        .clk     (clk),
        .wr_en   (a_wr),
        .wr_addr (item_addr),
        .wr_data (value_reg),
        .rd_en   (cmd.ab_rd),
        .rd_addr (mma_pkg::elem_addr(cmd.i, cmd.k)),
        .rd_data (a_rd)
    );

    mma_ram #(
        .WIDTH (mma_pkg::DATA_W),
        .DEPTH (mma_pkg::DEPTH)
    ) u_b_ram (
        .clk     (clk),
        .wr_en   (b_wr),
        .wr_addr (item_addr),
        .wr_data (value_reg),
        .rd_en   (cmd.ab_rd),
        .rd_addr (mma_pkg::elem_addr(cmd.k, cmd.j)),
        .rd_data (b_rd)
    );

    mma_ram #(
        .WIDTH (mma_pkg::DATA_W),
        .DEPTH (mma_pkg::DEPTH)
    ) u_c_ram (
        .clk     (clk),
        .wr_en   (c_wr),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_en   (cmd.c_rd),
        .rd_addr (c_rd_addr),
        .rd_data (c_rd)
    );

    // An entry of C that has never been written reads as zero.
    assign c_eff = c_vld_d1_reg ? c_rd : '0;

    always_comb
    begin
        c_valid_next = c_valid_reg;
        if (c_wr)
        begin
            c_valid_next[c_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg  <= '0;
            c_vld_d1_reg <= 1'b0;
            cload_d1_reg <= 1'b0;
            ab_d1_reg    <= 1'b0;
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            c_valid_reg  <= c_valid_next;
            if (cmd.c_rd)
            begin
                c_vld_d1_reg <= c_valid_reg[c_rd_addr];
            end
            cload_d1_reg <= cmd.c_rd && !cmd.use_item;
            ab_d1_reg    <= cmd.ab_rd;
            prod_vld_reg <= ab_d1_reg;
            done_reg     <= cmd.respond;
        end
    end

    assign prod_next = a_rd * b_rd;

    always_comb
    begin
        acc_next = acc_reg;
        if (cload_d1_reg)
        begin
            acc_next = {{(mma_pkg::ACC_W - mma_pkg::DATA_W - mma_pkg::FRAC_W){c_eff[31]}},
                        c_eff, {mma_pkg::FRAC_W{1'b0}}};
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(mma_pkg::ACC_W - mma_pkg::PROD_W){prod_reg[63]}},
                                  prod_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ab_d1_reg)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign acc_hi = acc_reg[mma_pkg::ACC_W-1:mma_pkg::FRAC_W+mma_pkg::DATA_W-1];

    always_comb
    begin
        if ((&acc_hi) || !(|acc_hi))
        begin
            sat_value = acc_reg[mma_pkg::FRAC_W+mma_pkg::DATA_W-1:mma_pkg::FRAC_W];
        end
        else if (acc_reg[mma_pkg::ACC_W-1])
        begin
            sat_value = mma_pkg::SAT_MIN;
        end
        else
        begin
            sat_value = mma_pkg::SAT_MAX;
        end
    end

    always_comb
    begin
        read_value_next = '0;
        if ((func_reg == mma_pkg::FUNC_RD_C) && item_ok)
        begin
            read_value_next = c_eff;
        end
        status_next = !item_ok;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

>>> sim/tb_matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_accumulate
// Self-checking testbench of the Q16.16 matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
// Commands are queued by phase, each phase under its own matrix sizes, and a
// clocked driver hands them to the block with random gaps. Every transfer is
// run through a local model of the A, B and C stores, and each result strobe
// is checked against the oldest predicted response. A and B entries are
// always written before a multiply-accumulate can use them.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_accumulate;

    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    localparam int FUNC_CODES  = 1 << FUNC_W;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } mma_cmd_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              status;
    } mma_resp_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [FUNC_W-1:0]            func = '0;
    logic [IDX_W-1:0]             row = '0;
    logic [IDX_W-1:0]             col = '0;
    logic signed [DATA_W-1:0]     element_value = '0;
    logic                         done;
    logic signed [DATA_W-1:0]     read_value;
    logic                         status;

    matrix_multiply_accumulate DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .row           (row),
        .col           (col),
        .element_value (element_value),
        .done          (done),
        .read_value    (read_value),
        .status        (status)
    );

    always #2 clk = ~clk;

    // Model state.
    logic [DATA_W-1:0]     a_mat [DEPTH];
    logic [DATA_W-1:0]     b_mat [DEPTH];
    logic [DATA_W-1:0]     c_mat [DEPTH] = '{default: '0};
    logic [CFG_DATA_W-1:0] size_rows = 5'd16;
    logic [CFG_DATA_W-1:0] size_inner = 5'd16;
    logic [CFG_DATA_W-1:0] size_cols = 5'd16;

    mma_cmd_t  cmd_q [$];
    mma_resp_t responses_due [$];
    int        errors = 0;
    int        cycle_count = 0;

    // Command generation state.
    bit a_filled [DEPTH];
    bit b_filled [DEPTH];
    int gen_rows = MAX_DIM;
    int gen_inner = MAX_DIM;
    int gen_cols = MAX_DIM;

    // Driver state.
    mma_cmd_t next_cmd;
    logic     xfer_seen = 1'b0;
    bit       holding = 1'b0;
    bit       no_gaps = 1'b0;
    int       idle_left = 0;

    function automatic int dim_of(logic [CFG_DATA_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic logic [DATA_W-1:0] c_entry_after_mac(int i, int j, int n2);
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        acc = longint'($signed(c_mat[i*MAX_DIM+j])) * 65536;
        for (int k = 0; k < n2; k++)
        begin
            acc = acc + longint'($signed(a_mat[i*MAX_DIM+k]))
                      * longint'($signed(b_mat[k*MAX_DIM+j]));
        end
        shifted = acc >>> 16;
        if (shifted > 80'sd2147483647)
            return SAT_MAX;
        if (shifted < -80'sd2147483648)
            return SAT_MIN;
        return shifted[DATA_W-1:0];
    endfunction

    function automatic mma_resp_t compute_response(mma_cmd_t cmd);
        mma_resp_t rsp;
        int        n1;
        int        n2;
        int        n3;
        int        addr;
        rsp.value  = '0;
        rsp.status = 1'b0;
        n1 = dim_of(size_rows);
        n2 = dim_of(size_inner);
        n3 = dim_of(size_cols);
        addr = int'(cmd.row) * MAX_DIM + int'(cmd.col);
        case (cmd.func)
            FUNC_WR_A:
                if (cmd.row < n1 && cmd.col < n2)
                    a_mat[addr] = cmd.value;
                else
                    rsp.status = 1'b1;
            FUNC_WR_B:
                if (cmd.row < n2 && cmd.col < n3)
                    b_mat[addr] = cmd.value;
                else
                    rsp.status = 1'b1;
            FUNC_WR_C:
                if (cmd.row < n1 && cmd.col < n3)
                    c_mat[addr] = cmd.value;
                else
                    rsp.status = 1'b1;
            FUNC_MAC:
                for (int i = 0; i < n1; i++)
                begin
                    for (int j = 0; j < n3; j++)
                    begin
                        c_mat[i*MAX_DIM+j] = c_entry_after_mac(i, j, n2);
                    end
                end
            FUNC_RD_C:
                if (cmd.row < n1 && cmd.col < n3)
                    rsp.value = c_mat[addr];
                else
                    rsp.status = 1'b1;
            default:
                rsp.status = 1'b1;
        endcase
        return rsp;
    endfunction

    function automatic logic [DATA_W-1:0] rand_elem(bit narrow);
        int r;
        r = $urandom_range(0, 9);
        if (!narrow && r == 0)
        begin
            case ($urandom_range(0, 4))
                0: return SAT_MAX;
                1: return SAT_MIN;
                2: return '0;
                3: return '1;
                default: return 32'h0001_0000;
            endcase
        end
        if (!narrow && r < 4)
            return $urandom();
        return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    function automatic int rand_index(int limit);
        if (limit > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(0, limit - 1);
        return $urandom_range(0, MAX_DIM - 1);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_cmd(input logic [FUNC_W-1:0] f, input int r, input int c,
                            input logic [DATA_W-1:0] v);
        mma_cmd_t cmd;
        cmd.func  = f;
        cmd.row   = IDX_W'(r);
        cmd.col   = IDX_W'(c);
        cmd.value = v;
        if (f == FUNC_WR_A && r < gen_rows && c < gen_inner)
            a_filled[r*MAX_DIM+c] = 1'b1;
        if (f == FUNC_WR_B && r < gen_inner && c < gen_cols)
            b_filled[r*MAX_DIM+c] = 1'b1;
        cmd_q.push_back(cmd);
    endtask

    // Writes every A and B entry in use that has never been written.
    task automatic fill_operands(input bit narrow);
        for (int i = 0; i < gen_rows; i++)
        begin
            for (int k = 0; k < gen_inner; k++)
            begin
                if (!a_filled[i*MAX_DIM+k])
                    push_cmd(FUNC_WR_A, i, k, rand_elem(narrow));
            end
        end
        for (int k = 0; k < gen_inner; k++)
        begin
            for (int j = 0; j < gen_cols; j++)
            begin
                if (!b_filled[k*MAX_DIM+j])
                    push_cmd(FUNC_WR_B, k, j, rand_elem(narrow));
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || holding || responses_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_sizes(input int r, input int k, input int c);
        wait_drained();
        write_size(CFG_ROWS_A, CFG_DATA_W'(r));
        write_size(CFG_INNER_DIM, CFG_DATA_W'(k));
        write_size(CFG_COLS_B, CFG_DATA_W'(c));
        gen_rows  = dim_of(CFG_DATA_W'(r));
        gen_inner = dim_of(CFG_DATA_W'(k));
        gen_cols  = dim_of(CFG_DATA_W'(c));
    endtask

    task automatic run_random(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
                push_cmd(FUNC_WR_A, rand_index(gen_rows), rand_index(gen_inner),
                         rand_elem(1'b0));
            else if (r < 44)
                push_cmd(FUNC_WR_B, rand_index(gen_inner), rand_index(gen_cols),
                         rand_elem(1'b0));
            else if (r < 54)
                push_cmd(FUNC_WR_C, rand_index(gen_rows), rand_index(gen_cols),
                         rand_elem(1'b0));
            else if (r < 60)
            begin
                fill_operands(1'b0);
                push_cmd(FUNC_MAC, $urandom_range(0, MAX_DIM - 1),
                         $urandom_range(0, MAX_DIM - 1), $urandom());
            end
            else if (r < 95)
                push_cmd(FUNC_RD_C, rand_index(gen_rows), rand_index(gen_cols), $urandom());
            else
                push_cmd(FUNC_W'($urandom_range(FUNC_RD_C + 1, FUNC_CODES - 1)),
                         $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                         $urandom());
        end
    endtask

    always @(negedge clk)
    begin
        if (xfer_seen)
            holding = 1'b0;
        if (!holding)
        begin
            if (idle_left > 0)
                idle_left--;
            else if (cmd_q.size() != 0)
            begin
                next_cmd = cmd_q.pop_front();
                func          <= next_cmd.func;
                row           <= next_cmd.row;
                col           <= next_cmd.col;
                element_value <= next_cmd.value;
                holding = 1'b1;
                if ($urandom_range(0, 49) == 0)
                    no_gaps = !no_gaps;
                idle_left = no_gaps ? 0 : pick_gap();
            end
        end
        start <= holding;
    end

    always @(posedge clk)
    begin
        mma_resp_t due;
        mma_cmd_t  seen;
        if (rst_n)
        begin
            if (done)
            begin
                if (responses_due.size() == 0)
                begin
                    $display("%0t: unexpected result, actual read_value %h status %b",
                             $time, read_value, status);
                    errors++;
                end
                else
                begin
                    due = responses_due.pop_front();
                    if (read_value !== due.value)
                    begin
                        $display("%0t: read_value mismatch, expected %h, actual %h",
                                 $time, due.value, read_value);
                        errors++;
                    end
                    if (status !== due.status)
                    begin
                        $display("%0t: status mismatch, expected %b, actual %b",
                                 $time, due.status, status);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ROWS_A:    size_rows = cfg_data;
                    CFG_INNER_DIM: size_inner = cfg_data;
                    CFG_COLS_B:    size_cols = cfg_data;
                    default:       ;
                endcase
            end
            if (start && !busy)
            begin
                seen.func  = func;
                seen.row   = row;
                seen.col   = col;
                seen.value = element_value;
                responses_due.push_back(compute_response(seen));
            end
        end
        xfer_seen <= start && !busy;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_matrix_multiply_accumulate: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Reset sizes: C reads as zero, edge indexes and unknown codes.
        push_cmd(FUNC_RD_C, 0, 0, '0);
        push_cmd(FUNC_RD_C, MAX_DIM - 1, MAX_DIM - 1, '0);
        push_cmd(FUNC_WR_C, MAX_DIM - 1, MAX_DIM - 1, SAT_MAX);
        push_cmd(FUNC_RD_C, MAX_DIM - 1, MAX_DIM - 1, '0);
        push_cmd(FUNC_WR_C, 0, MAX_DIM - 1, SAT_MIN);
        push_cmd(FUNC_RD_C, 0, MAX_DIM - 1, '1);
        push_cmd(FUNC_WR_A, MAX_DIM - 1, 0, SAT_MAX);
        push_cmd(FUNC_WR_B, 0, MAX_DIM - 1, SAT_MIN);
        for (int f = FUNC_RD_C + 1; f < FUNC_CODES; f++)
            push_cmd(FUNC_W'(f), MAX_DIM - 1, MAX_DIM - 1, '1);

        // Small sizes: indexes just outside, then a saturating accumulate.
        set_sizes(2, 3, 2);
        push_cmd(FUNC_WR_A, 2, 0, '1);
        push_cmd(FUNC_WR_A, 0, 3, '1);
        push_cmd(FUNC_WR_B, 3, 0, '1);
        push_cmd(FUNC_WR_B, 0, 2, '1);
        push_cmd(FUNC_WR_C, 0, 2, '1);
        push_cmd(FUNC_RD_C, 2, 0, '0);
        push_cmd(FUNC_RD_C, MAX_DIM - 1, MAX_DIM - 1, '0);
        fill_operands(1'b1);
        push_cmd(FUNC_WR_A, 0, 0, SAT_MIN);
        push_cmd(FUNC_WR_B, 0, 0, SAT_MIN);
        push_cmd(FUNC_WR_A, 1, 0, SAT_MIN);
        push_cmd(FUNC_WR_B, 0, 1, SAT_MAX);
        push_cmd(FUNC_MAC, 0, 0, '0);
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
                push_cmd(FUNC_RD_C, i, j, '0);
        end

        run_random(32);
        set_sizes(1, 1, 1);
        run_random(32);
        set_sizes(0, 4, 3);
        run_random(32);
        set_sizes(5, 0, 7);
        run_random(32);
        set_sizes(16, 16, 16);
        fill_operands(1'b0);
        run_random(32);
        set_sizes(31, 31, 31);
        run_random(32);
        set_sizes(17, 9, 30);
        run_random(32);
        set_sizes(3, 16, 1);
        run_random(32);
        set_sizes($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
        run_random(32);

        wait_drained();
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("tb_matrix_multiply_accumulate: done, clean");
        else
            $display("tb_matrix_multiply_accumulate: done, errors");
        $finish;
    end

endmodule
